// ===== src/pts_pkg.sv =====
// Shared widths and division constants for the pressure trend slope block.
package pts_pkg;

  localparam int unsigned WINDOW  = 24;
  localparam int unsigned PRESS_W = 17;
  localparam int unsigned MEAN_W  = 17;
  localparam int unsigned SLOPE_W = 22;

  localparam int unsigned IN_DATA_W  = ((PRESS_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((MEAN_W + SLOPE_W + 7) / 8) * 8;

  // Running sums: plain sum and sum of (2*i - (WINDOW-1)) * y_i.
  localparam int unsigned SUM_W  = PRESS_W + $clog2(WINDOW);
  localparam int unsigned WSUM_W = PRESS_W + $clog2(WINDOW * WINDOW / 4) + 1;
  localparam int unsigned MAG_W  = WSUM_W - 1;

  // Slope = round(512 * |S| / D), D = sum of squared doubled positions.
  localparam int unsigned SLOPE_SHIFT = 9;
  localparam int unsigned SLOPE_DEN   = WINDOW * (WINDOW * WINDOW - 1) / 3;
  localparam int unsigned SLOPE_HALF  = SLOPE_DEN / 2;
  localparam int unsigned DEN_W       = $clog2(SLOPE_DEN + 1);
  localparam int unsigned SN_W        = MAG_W + SLOPE_SHIFT + 1;
  localparam int unsigned SR_W        = SN_W - $clog2(SLOPE_DEN) + 1;
  localparam logic [SR_W-1:0] SLOPE_RECIP =
    SR_W'((64'd1 << SN_W) / 64'(SLOPE_DEN));

  // Mean = floor((sum + WINDOW/2) / WINDOW).
  localparam int unsigned MEAN_HALF = WINDOW / 2;
  localparam int unsigned WIN_W     = $clog2(WINDOW + 1);
  localparam int unsigned MN_W      = SUM_W + 1;
  localparam int unsigned MR_W      = MN_W - $clog2(WINDOW) + 1;
  localparam logic [MR_W-1:0] MEAN_RECIP =
    MR_W'((64'd1 << MN_W) / 64'(WINDOW));

  localparam int unsigned SLOPE_MAX_MAG = 2 ** (SLOPE_W - 1) - 1;
  localparam int unsigned SLOPE_MIN_MAG = 2 ** (SLOPE_W - 1);
  localparam int unsigned QX_W = ((SR_W > SLOPE_W) ? SR_W : SLOPE_W) + 1;

endpackage

// ===== src/pressure_trend_slope.sv =====
// Sliding-window pressure mean and least-squares trend slope, one sample per cycle when not stalled.
//
//   channel  dir  fields (lowest bit up)                     request moves
//   s_axis   in   pressure_pa[16:0], zero pad to 24 bits    one hourly sample
//   m_axis   out  window_mean_pa[16:0], trend_slope_q8[38:17] one result
//
// One request is taken every cycle while the output is not stalled; each result
// passes the running-sum, product and output registers in turn. The rate is set by
// the input sum update and the two middle-stage reciprocal multipliers, one stage each.
// Reset clears the window, both running sums and all stage valid flags.
// A stalled output holds its result; earlier stages keep moving into empty
// slots, so input is refused only when all three stages are full.
module pressure_trend_slope (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [pts_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // [16:0] pressure_pa
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [pts_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o   // [16:0] window_mean_pa,
                                                           // [38:17] trend_slope_q8
);
  import pts_pkg::*;

  logic                  acc, rdy1, rdy2, rdy3;
  logic                  v1_q, v2_q, v3_q;
  logic [PRESS_W-1:0]    win_q [WINDOW];
  logic [PRESS_W-1:0]    x, y0;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [WSUM_W-1:0]     wsum_q, wsum_d;

  logic                  neg_d;
  logic [WSUM_W-1:0]     s_abs;
  logic [SN_W-1:0]       sn_d;
  logic [SN_W+SR_W-1:0]  sp_d;
  logic [MN_W-1:0]       mn_d;
  logic [MN_W+MR_W-1:0]  mp_d;

  logic                  neg2_q;
  logic [SN_W-1:0]       sn2_q;
  logic [SN_W+SR_W-1:0]  sp2_q;
  logic [MN_W-1:0]       mn2_q;
  logic [MN_W+MR_W-1:0]  mp2_q;

  logic [SR_W-1:0]       sq_est, sq;
  logic [SR_W+DEN_W-1:0] s_prod;
  logic [SN_W-1:0]       s_rem;
  logic [QX_W-1:0]       qx;
  logic [MR_W-1:0]       mq_est, mq;
  logic [MR_W+WIN_W-1:0] m_prod;
  logic [MN_W-1:0]       m_rem;
  logic [MEAN_W-1:0]     mean_q, mean_d;
  logic [SLOPE_W-1:0]    slope_q, slope_d;

  // Each stage moves when the one after it is empty or moving.
  assign rdy3 = !v3_q || m_axis_tready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign acc  = s_axis_tvalid_i && rdy1;
  assign s_axis_tready_o = rdy1;

  // Shifting the window moves every old sample one position down, so the
  // weighted sum changes by -2*sum plus the terms of the leaving and new samples.
  always_comb begin
    x      = s_axis_tdata_i[PRESS_W-1:0];
    y0     = win_q[0];
    sum_d  = sum_q - SUM_W'(y0) + SUM_W'(x);
    wsum_d = wsum_q + WSUM_W'(y0) * WSUM_W'(WINDOW + 1) - (WSUM_W'(sum_q) << 1)
           + WSUM_W'(x) * WSUM_W'(WINDOW - 1);
  end

  // Reciprocal products; the estimate is at most one below the true quotient.
  always_comb begin
    neg_d = wsum_q[WSUM_W-1];
    s_abs = neg_d ? (~wsum_q + 1'b1) : wsum_q;
    sn_d  = (SN_W'(s_abs[MAG_W-1:0]) << SLOPE_SHIFT) + SN_W'(SLOPE_HALF);
    sp_d  = (SN_W+SR_W)'(sn_d) * (SN_W+SR_W)'(SLOPE_RECIP);
    mn_d  = MN_W'(sum_q) + MN_W'(MEAN_HALF);
    mp_d  = (MN_W+MR_W)'(mn_d) * (MN_W+MR_W)'(MEAN_RECIP);
  end

  always_comb begin
    sq_est = sp2_q[SN_W+SR_W-1:SN_W];
    s_prod = (SR_W+DEN_W)'(sq_est) * (SR_W+DEN_W)'(SLOPE_DEN);
    s_rem  = sn2_q - s_prod[SN_W-1:0];
    sq     = sq_est + SR_W'(s_rem >= SN_W'(SLOPE_DEN));
    qx     = QX_W'(sq);
    if (!neg2_q) begin
      if (qx > QX_W'(SLOPE_MAX_MAG)) slope_d = SLOPE_W'(SLOPE_MAX_MAG);
      else                           slope_d = SLOPE_W'(qx);
    end else begin
      if (qx > QX_W'(SLOPE_MIN_MAG)) slope_d = SLOPE_W'(SLOPE_MIN_MAG);
      else                           slope_d = SLOPE_W'(QX_W'(0) - qx);
    end

    mq_est = mp2_q[MN_W+MR_W-1:MN_W];
    m_prod = (MR_W+WIN_W)'(mq_est) * (MR_W+WIN_W)'(WINDOW);
    m_rem  = mn2_q - m_prod[MN_W-1:0];
    mq     = mq_est + MR_W'(m_rem >= MN_W'(WINDOW));
    mean_d = MEAN_W'(mq);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      sum_q  <= '0;
      wsum_q <= '0;
      for (int i = 0; i < WINDOW; i++) win_q[i] <= '0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (acc) begin
        sum_q  <= sum_d;
        wsum_q <= wsum_d;
        for (int i = 0; i < WINDOW - 1; i++) win_q[i] <= win_q[i+1];
        win_q[WINDOW-1] <= x;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      neg2_q <= neg_d;
      sn2_q  <= sn_d;
      sp2_q  <= sp_d;
      mn2_q  <= mn_d;
      mp2_q  <= mp_d;
    end
    if (v2_q && rdy3) begin
      mean_q  <= mean_d;
      slope_q <= slope_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({slope_q, mean_q});

endmodule

// ===== src/pts_checker.sv =====
// Port-level checks for the pressure trend slope block, bound to its top level.
module pts_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [pts_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [pts_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o
);
  import pts_pkg::*;

  logic acc;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  // A result that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed or dropped");

  // Input is refused only while a finished result waits to be taken.
  a_refuse_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input refused with a free output");

  // With the output draining, an accepted request reaches the output.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc ##1 m_axis_tready_i ##1 m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result missing after a free-running pass");

  // The padding bit above the slope field is always zero.
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[OUT_DATA_W-1:MEAN_W+SLOPE_W] == '0)
    else $error("output padding not zero");

endmodule

bind pressure_trend_slope pts_checker u_pts_checker (.*);
